// ----- src/i2cblm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cblm_pkg
// Shared types and constants for the bit-level I2C master.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cblm_pkg;

  // Command codes carried on func
  localparam logic [2:0] FN_START = 3'd0;
  localparam logic [2:0] FN_STOP  = 3'd1;
  localparam logic [2:0] FN_SEND  = 3'd2;
  localparam logic [2:0] FN_WAIT  = 3'd3;
  localparam logic [2:0] FN_READ  = 3'd4;

  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
  localparam logic [7:0] WAIT_COUNT_MAX    = 8'hFF;
  localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

  // One tick's worth of command and sampled bus input
  typedef struct packed {
    logic       sda_in;
    logic       cmd_valid;
    logic [2:0] func;
    logic [7:0] tx_byte;
    logic       send_ack;
  } tick_t;

  // Line levels and status reported for one tick
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_fail;
  } res_t;

endpackage

`default_nettype wire

// ----- src/i2cblm_seq.sv -----
// ----------------------------------------------------------------------------
// i2cblm_seq
// Bus sequencer: advances one segment per accepted tick and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cblm_seq (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic [7:0]          cfg_wr_data,
  input  wire logic                tick_en,
  input  wire i2cblm_pkg::tick_t   tick,
  output i2cblm_pkg::res_t         res
);
  import i2cblm_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_ST1, PH_SP1, PH_SP2, PH_TO1, PH_TO2, PH_WA,
    PH_TXH, PH_TXL, PH_TXE, PH_RXL, PH_RXS, PH_RXA, PH_RXE
  } phase_t;

  phase_t     phase, phase_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] wait_count, wait_count_next;
  logic       scl_reg, scl_reg_next;
  logic       sda_reg, sda_reg_next;
  logic       ack_choice, ack_choice_next;
  logic       fail_flag, fail_flag_next;
  logic [7:0] rx_hold, rx_hold_next;
  logic [7:0] ack_timeout;
  logic       done;

  // Acknowledge sample: base count is cleared when the wait command is taken
  logic [7:0] wc_base, wc_inc;
  logic       ack_low, ack_expired;
  logic       in_wait;

  assign in_wait     = (phase == PH_WA);
  assign wc_base     = in_wait ? wait_count : 8'd0;
  assign wc_inc      = (wc_base < WAIT_COUNT_MAX) ? wc_base + 8'd1 : wc_base;
  assign ack_low     = !tick.sda_in;
  assign ack_expired = (wc_inc > ack_timeout);

  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    shift_reg_next  = shift_reg;
    wait_count_next = wait_count;
    scl_reg_next    = scl_reg;
    sda_reg_next    = sda_reg;
    ack_choice_next = ack_choice;
    fail_flag_next  = fail_flag;
    rx_hold_next    = rx_hold;
    done            = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        if (tick.cmd_valid) begin
          unique case (tick.func)
            FN_START: begin
              scl_reg_next = 1'b1;
              sda_reg_next = 1'b1;
              phase_next   = PH_ST1;
            end
            FN_STOP: begin
              scl_reg_next = 1'b1;
              phase_next   = PH_SP1;
            end
            FN_SEND: begin
              scl_reg_next   = 1'b0;
              shift_reg_next = tick.tx_byte;
              bit_count_next = 4'd0;
              phase_next     = PH_TXH;
            end
            FN_WAIT: begin
              fail_flag_next = 1'b0;
              sda_reg_next   = 1'b1;
              if (ack_low) begin
                wait_count_next = 8'd0;
                scl_reg_next    = 1'b0;
                done            = 1'b1;
              end else begin
                wait_count_next = wc_inc;
                scl_reg_next    = 1'b1;
                phase_next      = ack_expired ? PH_TO1 : PH_WA;
              end
            end
            FN_READ: begin
              sda_reg_next    = 1'b1;
              ack_choice_next = tick.send_ack;
              shift_reg_next  = 8'd0;
              bit_count_next  = 4'd0;
              phase_next      = PH_RXL;
            end
            default: ;  // unknown command codes are ignored
          endcase
        end
      end
      PH_ST1: begin
        sda_reg_next = 1'b0;
        phase_next   = PH_IDLE;
        done         = 1'b1;
      end
      PH_SP1: begin
        sda_reg_next = 1'b0;
        phase_next   = PH_SP2;
      end
      PH_SP2: begin
        sda_reg_next = 1'b1;
        phase_next   = PH_IDLE;
        done         = 1'b1;
      end
      PH_TO1: begin
        sda_reg_next = 1'b0;
        phase_next   = PH_TO2;
      end
      PH_TO2: begin
        sda_reg_next   = 1'b1;
        fail_flag_next = 1'b1;
        phase_next     = PH_IDLE;
        done           = 1'b1;
      end
      PH_WA: begin
        if (ack_low) begin
          scl_reg_next = 1'b0;
          phase_next   = PH_IDLE;
          done         = 1'b1;
        end else begin
          wait_count_next = wc_inc;
          if (ack_expired) begin
            scl_reg_next = 1'b1;
            phase_next   = PH_TO1;
          end
        end
      end
      PH_TXH: begin
        sda_reg_next   = shift_reg[7];
        shift_reg_next = {shift_reg[6:0], 1'b0};
        scl_reg_next   = 1'b1;
        phase_next     = PH_TXL;
      end
      PH_TXL: begin
        scl_reg_next   = 1'b0;
        bit_count_next = bit_count + 4'd1;
        phase_next     = (bit_count_next >= BITS_PER_BYTE) ? PH_TXE : PH_TXH;
      end
      PH_TXE: begin
        phase_next = PH_IDLE;
        done       = 1'b1;
      end
      PH_RXL: begin
        scl_reg_next = 1'b0;
        phase_next   = PH_RXS;
      end
      PH_RXS: begin
        shift_reg_next = {shift_reg[6:0], tick.sda_in};
        scl_reg_next   = 1'b0;
        bit_count_next = bit_count + 4'd1;
        phase_next     = (bit_count_next >= BITS_PER_BYTE) ? PH_RXA : PH_RXS;
      end
      PH_RXA: begin
        sda_reg_next = !ack_choice;
        scl_reg_next = 1'b1;
        phase_next   = PH_RXE;
      end
      PH_RXE: begin
        scl_reg_next = 1'b0;
        rx_hold_next = shift_reg;
        phase_next   = PH_IDLE;
        done         = 1'b1;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    res.scl_level = scl_reg_next;
    res.sda_level = sda_reg_next;
    res.busy_res  = (phase_next != PH_IDLE);
    res.done_res  = done;
    res.rx_byte   = rx_hold_next;
    res.ack_fail  = fail_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_count   <= 4'd0;
      shift_reg   <= 8'd0;
      wait_count  <= 8'd0;
      scl_reg     <= 1'b1;
      sda_reg     <= 1'b1;
      ack_choice  <= 1'b0;
      fail_flag   <= 1'b0;
      rx_hold     <= 8'd0;
      ack_timeout <= ACK_TIMEOUT_RESET;
    end else begin
      if (cfg_wr_en) begin
        ack_timeout <= cfg_wr_data;
      end
      if (tick_en) begin
        phase      <= phase_next;
        bit_count  <= bit_count_next;
        shift_reg  <= shift_reg_next;
        wait_count <= wait_count_next;
        scl_reg    <= scl_reg_next;
        sda_reg    <= sda_reg_next;
        ack_choice <= ack_choice_next;
        fail_flag  <= fail_flag_next;
        rx_hold    <= rx_hold_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/i2cblm_skid.sv -----
// ----------------------------------------------------------------------------
// i2cblm_skid
// Result register with a skid stage; ready toward the sequencer is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cblm_skid (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire i2cblm_pkg::res_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output i2cblm_pkg::res_t       out_data
);
  import i2cblm_pkg::*;

  logic main_valid;
  logic skid_valid;
  res_t main_data;
  res_t skid_data;
  logic in_fire;
  logic main_free;

  assign in_ready  = !skid_valid;
  assign in_fire   = in_valid && in_ready;
  assign main_free = !main_valid || out_ready;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      main_valid <= skid_valid || in_fire;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (main_free) begin
      main_data <= skid_valid ? skid_data : in_data;
    end else if (in_fire) begin
      skid_data <= in_data;
    end
  end

endmodule

`default_nettype wire

// ----- src/i2c_bit_level_master.sv -----
// ----------------------------------------------------------------------------
// i2c_bit_level_master
// Bit-level I2C master sequencer stepped one bus delay tick per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction (in_valid/in_ready) is one bus delay tick: the
//   sampled data line plus, when the sequencer is idle, an optional command
//   (start, stop, send byte, wait acknowledge, read byte). Each tick yields
//   exactly one output transaction (out_valid/out_ready) with the driven
//   clock and data levels, busy, done, the last received byte and the
//   acknowledge failure flag.
//   Each result is registered in the result buffer when its tick is taken.
//   Throughput: one tick per cycle while in_ready is high; the sequencer
//   advances in a single pass of next-state logic when the tick is taken.
//   The user must write ack_timeout through cfg_wr_en/cfg_wr_data while no
//   tick is in flight (the block does not enforce it); it resets to 250.
//   Reset: sequencer idle, both lines released, flags cleared, no result
//   pending.
//   Output stall: a two-entry result buffer absorbs one extra tick; in_ready
//   drops only when both entries are full.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_bit_level_master (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       sda_in,
  input  wire logic       cmd_valid,
  input  wire logic [2:0] func,
  input  wire logic [7:0] tx_byte,
  input  wire logic       send_ack,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            scl_level,
  output logic            sda_level,
  output logic            busy_res,
  output logic            done_res,
  output logic [7:0]      rx_byte,
  output logic            ack_fail
);
  import i2cblm_pkg::*;

  tick_t tick;
  res_t  step_res;
  res_t  out_res;
  logic  tick_en;

  assign tick.sda_in    = sda_in;
  assign tick.cmd_valid = cmd_valid;
  assign tick.func      = func;
  assign tick.tx_byte   = tx_byte;
  assign tick.send_ack  = send_ack;

  assign tick_en = in_valid && in_ready;

  i2cblm_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .tick_en     (tick_en),
    .tick        (tick),
    .res         (step_res)
  );

  i2cblm_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (step_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign scl_level = out_res.scl_level;
  assign sda_level = out_res.sda_level;
  assign busy_res  = out_res.busy_res;
  assign done_res  = out_res.done_res;
  assign rx_byte   = out_res.rx_byte;
  assign ack_fail  = out_res.ack_fail;

endmodule

`default_nettype wire

// ----- sim/tb_i2c_bit_level_master.sv -----
// ----------------------------------------------------------------------------
// tb_i2c_bit_level_master
// Self-checking bench for the bit-level I2C master. It plays bus ticks with
// commands, mirrors the sequencer in a behavioral model and checks every
// result transaction, field by field, under random input and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_i2c_bit_level_master;
  import i2cblm_pkg::*;

  localparam int         RAND_TICKS  = 1500;
  localparam int         STALL_LIMIT = 2000;
  localparam int         HOLD_CYCLES = 60;
  localparam logic [2:0] FN_MAX      = 3'd7;

  typedef enum logic [4:0] {
    PH_IDLE, PH_START_HI, PH_STOP_1, PH_STOP_2, PH_ABORT_1, PH_ABORT_2,
    PH_ACK_WAIT, PH_TX_HI, PH_TX_LO, PH_TX_END, PH_RX_REL, PH_RX_SAMPLE,
    PH_RX_ACK, PH_RX_END
  } seq_phase_t;

  typedef struct {
    logic        cmd;
    logic [2:0]  fn;
    logic [7:0]  txb;
    logic        ack;
    logic [15:0] sda_pat;   // sda_in for the first 16 ticks of the command
    logic        sda_tail;  // sda_in after that
    bit          chk;
    res_t        want;      // typed result for the tick that ends the command
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       sda_in = 1'b1;
  logic       cmd_valid = 1'b0;
  logic [2:0] func = FN_START;
  logic [7:0] tx_byte = '0;
  logic       send_ack = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_fail;

  // sequencer model state
  seq_phase_t m_phase    = PH_IDLE;
  logic [7:0] m_timeout  = ACK_TIMEOUT_RESET;
  logic [3:0] m_bits     = '0;
  logic [7:0] m_shift    = '0;
  logic [7:0] m_wait_cnt = '0;
  logic       m_scl      = 1'b1;
  logic       m_sda      = 1'b1;
  logic       m_ack_sel  = 1'b0;
  logic       m_fail     = 1'b0;
  logic [7:0] m_rx_hold  = '0;

  res_t expected_res[$];
  int   mismatches = 0;
  int   ticks_sent = 0;
  int   send_idle_pct = 27;
  int   recv_idle_pct = 58;
  bit   hold_req = 1'b0;
  int   stall_cycles = 0;

  i2c_bit_level_master i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sda_in      (sda_in),
    .cmd_valid   (cmd_valid),
    .func        (func),
    .tx_byte     (tx_byte),
    .send_ack    (send_ack),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .scl_level   (scl_level),
    .sda_level   (sda_level),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .rx_byte     (rx_byte),
    .ack_fail    (ack_fail)
  );

  always #5 clk = ~clk;

  // One acknowledge sample; a low line ends the wait with success
  task automatic ack_sample(input logic sda, output logic fin);
    fin = 1'b0;
    if (!sda) begin
      m_scl   = 1'b0;
      m_phase = PH_IDLE;
      fin     = 1'b1;
    end else begin
      if (m_wait_cnt != WAIT_COUNT_MAX) m_wait_cnt++;
      if (m_wait_cnt > m_timeout) begin
        m_scl   = 1'b1;
        m_phase = PH_ABORT_1;
      end else begin
        m_phase = PH_ACK_WAIT;
      end
    end
  endtask

  task automatic advance_sequencer(input tick_t t, output res_t r);
    logic fin;
    fin = 1'b0;
    unique case (m_phase)
      PH_IDLE: begin
        if (t.cmd_valid) begin
          unique case (t.func)
            FN_START: begin
              m_scl = 1'b1; m_sda = 1'b1; m_phase = PH_START_HI;
            end
            FN_STOP: begin
              m_scl = 1'b1; m_phase = PH_STOP_1;
            end
            FN_SEND: begin
              m_scl = 1'b0; m_shift = t.tx_byte; m_bits = '0; m_phase = PH_TX_HI;
            end
            FN_WAIT: begin
              m_fail = 1'b0; m_wait_cnt = '0; m_sda = 1'b1; m_scl = 1'b1;
              ack_sample(t.sda_in, fin);
            end
            FN_READ: begin
              m_sda = 1'b1; m_ack_sel = t.send_ack; m_shift = '0; m_bits = '0;
              m_phase = PH_RX_REL;
            end
            default: ;
          endcase
        end
      end
      PH_START_HI: begin
        m_sda = 1'b0; m_phase = PH_IDLE; fin = 1'b1;
      end
      PH_STOP_1: begin
        m_sda = 1'b0; m_phase = PH_STOP_2;
      end
      PH_STOP_2: begin
        m_sda = 1'b1; m_phase = PH_IDLE; fin = 1'b1;
      end
      PH_ABORT_1: begin
        m_sda = 1'b0; m_phase = PH_ABORT_2;
      end
      PH_ABORT_2: begin
        m_sda = 1'b1; m_fail = 1'b1; m_phase = PH_IDLE; fin = 1'b1;
      end
      PH_ACK_WAIT: ack_sample(t.sda_in, fin);
      PH_TX_HI: begin
        m_sda   = m_shift[7];
        m_shift = {m_shift[6:0], 1'b0};
        m_scl   = 1'b1;
        m_phase = PH_TX_LO;
      end
      PH_TX_LO: begin
        m_scl = 1'b0;
        m_bits++;
        m_phase = (m_bits >= BITS_PER_BYTE) ? PH_TX_END : PH_TX_HI;
      end
      PH_TX_END: begin
        m_phase = PH_IDLE; fin = 1'b1;
      end
      PH_RX_REL: begin
        m_scl = 1'b0; m_phase = PH_RX_SAMPLE;
      end
      PH_RX_SAMPLE: begin
        // clock is high only inside this tick, so results show it low
        m_shift = {m_shift[6:0], t.sda_in};
        m_scl   = 1'b0;
        m_bits++;
        m_phase = (m_bits >= BITS_PER_BYTE) ? PH_RX_ACK : PH_RX_SAMPLE;
      end
      PH_RX_ACK: begin
        m_sda = ~m_ack_sel; m_scl = 1'b1; m_phase = PH_RX_END;
      end
      PH_RX_END: begin
        m_scl = 1'b0; m_rx_hold = m_shift; m_phase = PH_IDLE; fin = 1'b1;
      end
      default: m_phase = PH_IDLE;
    endcase
    r.scl_level = m_scl;
    r.sda_level = m_sda;
    r.busy_res  = (m_phase != PH_IDLE);
    r.done_res  = fin;
    r.rx_byte   = m_rx_hold;
    r.ack_fail  = m_fail;
  endtask

  function automatic res_t res_of(logic scl, logic sda, logic busy, logic done,
                                  logic [7:0] rx, logic fail);
    res_t r;
    r.scl_level = scl;
    r.sda_level = sda;
    r.busy_res  = busy;
    r.done_res  = done;
    r.rx_byte   = rx;
    r.ack_fail  = fail;
    return r;
  endfunction

  // sda_in pattern that feeds a byte to a read, MSB on the third tick
  function automatic logic [15:0] rd_pat(logic [7:0] b);
    logic [15:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) p[2 + i] = b[7 - i];
    return p;
  endfunction

  function automatic dir_row_t mk_row(logic cmd, logic [2:0] fn, logic [7:0] txb,
                                      logic ack, logic [15:0] pat, logic tail,
                                      bit chk, res_t want);
    dir_row_t d;
    d.cmd = cmd; d.fn = fn; d.txb = txb; d.ack = ack;
    d.sda_pat = pat; d.sda_tail = tail; d.chk = chk; d.want = want;
    return d;
  endfunction

  // tick while a command runs; any command offered here must be ignored
  function automatic tick_t busy_tick(logic sda);
    tick_t b;
    b.sda_in    = sda;
    b.cmd_valid = 1'($urandom_range(0, 1));
    b.func      = 3'($urandom_range(0, FN_MAX));
    b.tx_byte   = 8'($urandom_range(0, 255));
    b.send_ack  = 1'($urandom_range(0, 1));
    return b;
  endfunction

  task automatic issue_tick(input tick_t t, input bit use_want, input res_t want);
    res_t r;
    @(negedge clk);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    sda_in    <= t.sda_in;
    cmd_valid <= t.cmd_valid;
    func      <= t.func;
    tx_byte   <= t.tx_byte;
    send_ack  <= t.send_ack;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_sequencer(t, r);
    if (use_want && m_phase == PH_IDLE) r = want;
    expected_res.push_back(r);
    ticks_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_res.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    res_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_res.size() == 0) begin
        $error("result transaction with no tick outstanding");
        mismatches++;
      end else begin
        e = expected_res.pop_front();
        check_field("scl_level", 8'(e.scl_level), 8'(scl_level));
        check_field("sda_level", 8'(e.sda_level), 8'(sda_level));
        check_field("busy_res",  8'(e.busy_res),  8'(busy_res));
        check_field("done_res",  8'(e.done_res),  8'(done_res));
        check_field("rx_byte",   e.rx_byte,       rx_byte);
        check_field("ack_fail",  8'(e.ack_fail),  8'(ack_fail));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    dir_row_t   dir_rows[$];
    dir_row_t   d;
    tick_t      c;
    logic [7:0] cfg_vals[6];
    int         rnd_base;
    int         rnd_done;
    int         phase_end;
    int         hi_run;
    bit         waiting;
    bit         long_wait;
    bit         hold_done;

    hold_done = 1'b0;
    cfg_vals  = '{8'd0, 8'd1, WAIT_COUNT_MAX, 8'($urandom_range(2, 30)), 8'd3,
                  ACK_TIMEOUT_RESET};

    dir_rows.push_back(mk_row(1'b0, FN_START, 8'h00, 1'b0, 16'hFFFF, 1'b1, 1'b1,
                              res_of(1, 1, 0, 0, 8'h00, 0)));
    // unknown codes leave the sequencer idle
    dir_rows.push_back(mk_row(1'b1, 3'(FN_READ + 1), 8'h00, 1'b0, 16'hFFFF, 1'b1, 1'b1,
                              res_of(1, 1, 0, 0, 8'h00, 0)));
    dir_rows.push_back(mk_row(1'b1, FN_MAX, 8'hFF, 1'b1, 16'h0000, 1'b0, 1'b1,
                              res_of(1, 1, 0, 0, 8'h00, 0)));
    dir_rows.push_back(mk_row(1'b1, FN_START, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b1,
                              res_of(1, 0, 0, 1, 8'h00, 0)));
    dir_rows.push_back(mk_row(1'b1, FN_SEND, 8'hFF, 1'b0, 16'hA5A5, 1'b1, 1'b1,
                              res_of(0, 1, 0, 1, 8'h00, 0)));
    dir_rows.push_back(mk_row(1'b1, FN_WAIT, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b1,
                              res_of(0, 1, 0, 1, 8'h00, 0)));
    dir_rows.push_back(mk_row(1'b1, FN_SEND, 8'h00, 1'b1, 16'h5A5A, 1'b0, 1'b1,
                              res_of(0, 0, 0, 1, 8'h00, 0)));
    dir_rows.push_back(mk_row(1'b1, FN_WAIT, 8'h00, 1'b0, 16'h0007, 1'b0, 1'b1,
                              res_of(0, 1, 0, 1, 8'h00, 0)));
    dir_rows.push_back(mk_row(1'b1, FN_READ, 8'h00, 1'b1, rd_pat(8'hA5), 1'b0, 1'b1,
                              res_of(0, 0, 0, 1, 8'hA5, 0)));
    dir_rows.push_back(mk_row(1'b1, FN_READ, 8'h00, 1'b0, rd_pat(8'hFF), 1'b1, 1'b1,
                              res_of(0, 1, 0, 1, 8'hFF, 0)));
    dir_rows.push_back(mk_row(1'b1, FN_READ, 8'hFF, 1'b1, rd_pat(8'h00), 1'b1, 1'b1,
                              res_of(0, 0, 0, 1, 8'h00, 0)));
    dir_rows.push_back(mk_row(1'b1, FN_SEND, 8'h80, 1'b0, 16'h0F0F, 1'b0, 1'b0,
                              '0));
    dir_rows.push_back(mk_row(1'b1, FN_STOP, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b1,
                              res_of(1, 1, 0, 1, 8'h00, 0)));
    // line stays high: times out at the reset timeout and sends a stop
    dir_rows.push_back(mk_row(1'b1, FN_WAIT, 8'h00, 1'b0, 16'hFFFF, 1'b1, 1'b1,
                              res_of(1, 1, 0, 1, 8'h00, 1)));
    dir_rows.push_back(mk_row(1'b1, FN_START, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b1,
                              res_of(1, 0, 0, 1, 8'h00, 1)));
    dir_rows.push_back(mk_row(1'b1, FN_SEND, 8'h5A, 1'b1, 16'h3C3C, 1'b1, 1'b0,
                              '0));
    dir_rows.push_back(mk_row(1'b1, FN_READ, 8'h00, 1'b0, rd_pat(8'h3C), 1'b0, 1'b0,
                              '0));
    // a new wait clears the failure flag
    dir_rows.push_back(mk_row(1'b1, FN_WAIT, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b1,
                              res_of(0, 1, 0, 1, 8'h3C, 0)));
    dir_rows.push_back(mk_row(1'b1, FN_STOP, 8'h00, 1'b0, 16'h1234, 1'b1, 1'b0,
                              '0));

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      d = dir_rows[i];
      c.sda_in    = d.sda_pat[0];
      c.cmd_valid = d.cmd;
      c.func      = d.fn;
      c.tx_byte   = d.txb;
      c.send_ack  = d.ack;
      issue_tick(c, d.chk, d.want);
      for (int k = 1; m_phase != PH_IDLE; k++)
        issue_tick(busy_tick((k < 16) ? d.sda_pat[k] : d.sda_tail), d.chk, d.want);
    end

    rnd_base = ticks_sent;
    for (int p = 0; p < 6; p++) begin
      // register changes only with the sequencer idle and nothing in flight
      drain_results();
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= cfg_vals[p];
      m_timeout    = cfg_vals[p];
      @(negedge clk);
      cfg_wr_en   <= 1'b0;
      long_wait = (cfg_vals[p] == WAIT_COUNT_MAX);
      phase_end = ticks_sent + RAND_TICKS / 6;
      while (ticks_sent < phase_end) begin
        rnd_done = ticks_sent - rnd_base;
        if (rnd_done < RAND_TICKS / 3) begin
          send_idle_pct = 27; recv_idle_pct = 58;
        end else if (rnd_done < 2 * RAND_TICKS / 3) begin
          send_idle_pct = 58; recv_idle_pct = 27;
        end else begin
          send_idle_pct = 0; recv_idle_pct = 0;
        end
        if (!hold_done && rnd_done >= 1100) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        c.cmd_valid = ($urandom_range(0, 9) != 0);
        c.func      = ($urandom_range(0, 99) < 8) ?
                      3'($urandom_range(FN_READ + 1, FN_MAX)) :
                      3'($urandom_range(FN_START, FN_READ));
        c.tx_byte   = 8'($urandom_range(0, 255));
        c.send_ack  = 1'($urandom_range(0, 1));
        hi_run = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) :
                                               $urandom_range(0, 6);
        if (long_wait) begin
          // long enough to saturate the high-sample count
          c.cmd_valid = 1'b1;
          c.func      = FN_WAIT;
          hi_run      = 300;
          long_wait   = 1'b0;
        end
        waiting  = c.cmd_valid && (c.func == FN_WAIT);
        c.sda_in = waiting ? (hi_run > 0) : 1'($urandom_range(0, 1));
        issue_tick(c, 1'b0, '0);
        for (int k = 1; m_phase != PH_IDLE; k++)
          issue_tick(busy_tick(waiting ? (k < hi_run) : 1'($urandom_range(0, 1))),
                     1'b0, '0);
      end
    end

    drain_results();
    repeat (5) @(negedge clk);
    if (mismatches == 0 && expected_res.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
